FILE: src/tcse_pkg.sv
package tcse_pkg;

    localparam int VAL_W     = 32;
    localparam int IDX_W     = 10;
    localparam int NUM_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int WIDE_W    = 40;
    localparam int HALF_W    = 20;
    localparam int PART_W    = HALF_W + VAL_W;
    localparam int ACC_W     = WIDE_W + VAL_W;
    localparam int DIV_W     = 36;
    localparam int DIG_W     = 4;
    localparam int CNT_W     = 4;
    localparam int WIN_N     = 6;
    localparam int WIN_IDX_W = 3;

    localparam int MIN_POINTS = 5;
    localparam int WIN_BACK   = 2;

    localparam logic [CNT_W-1:0] READ_LAST   = CNT_W'(WIN_N);
    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_W / DIG_W - 1);
    localparam logic [CNT_W-1:0] HORNER_LAST = CNT_W'(2);

    localparam logic [NUM_W-1:0] NUM_POINTS_RST  = NUM_W'(5);
    localparam logic [VAL_W-1:0] INV_SPACING_RST = VAL_W'(65536);

    // product magnitude clip, well past the saturation point of the results
    localparam logic [WIDE_W-1:0] MUL_CAP = WIDE_W'(64'h40_0000_0000);

    localparam logic signed [WIDE_W-1:0] SAT_HI = 40'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -40'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_POINTS  = 2'd0,
        CFG_X_ORIGIN    = 2'd1,
        CFG_INV_SPACING = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CAPTURE,
        OP_LOC_LO,
        OP_LOC_HI,
        OP_CELL,
        OP_READ,
        OP_PREP,
        OP_DIV,
        OP_FIN,
        OP_V_LO,
        OP_V_HI,
        OP_V_ADD,
        OP_H_LO,
        OP_H_HI,
        OP_H_ADD,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic [CNT_W-1:0]   idx;
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOC_LO,
        ST_LOC_HI,
        ST_CELL,
        ST_READ,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_V_LO,
        ST_V_HI,
        ST_V_ADD,
        ST_H_LO,
        ST_H_HI,
        ST_H_ADD,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SK_FWD,
        SK_BWD,
        SK_HALF,
        SK_INNER
    } slope_kind_t;

    function automatic logic [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = VAL_W'(32'h7FFF_FFFF);
        end
        else if (v < SAT_LO)
        begin
            r = VAL_W'(32'h8000_0000);
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/tcse_ram.sv
module tcse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/tcse_div3.sv
module tcse_div3 import tcse_pkg::*; (
    input  logic             clk,
    input  logic             load,
    input  logic             step,
    input  logic [DIV_W-1:0] numer,
    output logic [DIV_W-1:0] quot
);

    // digit of a 6-bit partial remainder over 3: (v * 43) >> 7 is exact below 48
    localparam logic [11:0] RECIP = 12'd43;
    localparam int          RSH   = 7;

    logic [DIV_W-1:0] num_reg;
    logic [DIV_W-1:0] quot_reg;
    logic [1:0]       rem_reg;

    logic [5:0]       part;
    logic [11:0]      prod;
    logic [DIG_W-1:0] digit;
    logic [5:0]       rem_full;

    always_comb
    begin
        part     = {rem_reg, num_reg[DIV_W-1 -: DIG_W]};
        prod     = 12'(part) * RECIP;
        digit    = prod[RSH +: DIG_W];
        rem_full = part - 6'(digit) * 6'd3;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg  <= numer;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (step)
        begin
            num_reg  <= num_reg << DIG_W;
            quot_reg <= {quot_reg[DIV_W-DIG_W-1:0], digit};
            rem_reg  <= rem_full[1:0];
        end
    end

    assign quot = quot_reg;

endmodule

FILE: src/tcse_ctrl.sv
module tcse_ctrl import tcse_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    action,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.idx        = cnt_reg;
        in_stall       = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action)
                    begin
                        cmd.op     = OP_CAPTURE;
                        state_next = ST_LOC_LO;
                    end
                    else
                    begin
                        cmd.op = OP_LOAD;
                    end
                end
            end
            ST_LOC_LO:
            begin
                cmd.op     = OP_LOC_LO;
                state_next = ST_LOC_HI;
            end
            ST_LOC_HI:
            begin
                cmd.op     = OP_LOC_HI;
                state_next = ST_CELL;
            end
            ST_CELL:
            begin
                cmd.op     = OP_CELL;
                cnt_next   = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.op = OP_READ;
                if (cnt_reg == READ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_PREP;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_PREP:
            begin
                cmd.op     = OP_PREP;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FIN:
            begin
                cmd.op     = OP_FIN;
                cnt_next   = '0;
                state_next = ST_V_LO;
            end
            ST_V_LO:
            begin
                cmd.op     = OP_V_LO;
                state_next = ST_V_HI;
            end
            ST_V_HI:
            begin
                cmd.op     = OP_V_HI;
                state_next = ST_V_ADD;
            end
            ST_V_ADD:
            begin
                cmd.op = OP_V_ADD;
                if (cnt_reg == HORNER_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_H_LO;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_V_LO;
                end
            end
            ST_H_LO:
            begin
                cmd.op     = OP_H_LO;
                state_next = ST_H_HI;
            end
            ST_H_HI:
            begin
                cmd.op     = OP_H_HI;
                state_next = ST_H_ADD;
            end
            ST_H_ADD:
            begin
                cmd.op = OP_H_ADD;
                if (cnt_reg == HORNER_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_H_LO;
                end
            end
            ST_OUT:
            begin
                // hold until the previous result transaction has gone
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/tcse_datapath.sv
module tcse_datapath import tcse_pkg::*; #(
    parameter int DEPTH     = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [VAL_W-1:0]        cfg_data,
    input  logic [IDX_W-1:0]        sample_index,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic signed [VAL_W-1:0] query_x,
    output logic signed [VAL_W-1:0] func_value,
    output logic signed [VAL_W-1:0] func_slope
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam int PW = FRAC_BITS + 1;
    localparam int XW = VAL_W + 5;

    logic [NUM_W-1:0]        num_points_reg;
    logic signed [VAL_W-1:0] x_origin_reg;
    logic [VAL_W-1:0]        inv_spacing_reg;

    logic signed [VAL_W-1:0]  query_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [AW-1:0]            cell_reg;
    logic [PW-1:0]            p_reg;
    logic signed [VAL_W-1:0]  w_reg [WIN_N];
    logic signed [WIDE_W-1:0] s_reg [2];
    slope_kind_t              kind_reg [2];
    logic                     sneg_reg [2];
    logic signed [WIDE_W-1:0] cc_reg;
    logic signed [WIDE_W-1:0] val_reg;
    logic signed [WIDE_W-1:0] h_reg;
    logic [VAL_W-1:0]         fv_reg;
    logic [VAL_W-1:0]         fs_reg;

    logic [NW-1:0]            n_pts;
    logic signed [VAL_W:0]    x_off;
    logic                     ram_we;
    logic [AW-1:0]            ram_raddr;
    logic [VAL_W-1:0]         ram_rdata;

    // ------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg  <= NUM_POINTS_RST;
            x_origin_reg    <= '0;
            inv_spacing_reg <= INV_SPACING_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUM_POINTS:  num_points_reg  <= cfg_data[NUM_W-1:0];
                CFG_X_ORIGIN:    x_origin_reg    <= cfg_data;
                CFG_INV_SPACING: inv_spacing_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (num_points_reg < NUM_W'(MIN_POINTS))
        begin
            n_pts = NW'(MIN_POINTS);
        end
        else if (32'(num_points_reg) > 32'(DEPTH))
        begin
            n_pts = NW'(DEPTH);
        end
        else
        begin
            n_pts = NW'(num_points_reg);
        end
    end

    // ------------------------------------------------------------------
    // sample table
    assign ram_we    = (cmd.op == OP_LOAD) && (32'(sample_index) < 32'(DEPTH));
    assign ram_raddr = cell_reg + AW'(cmd.idx) - AW'(WIN_BACK);

    tcse_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(sample_index)),
        .wdata (sample_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // shared multiplier: 40-bit magnitude times 32 bits in two halves
    logic [WIDE_W-1:0]        mag;
    logic [VAL_W-1:0]         mult;
    logic                     op_neg;
    logic                     is_lo;
    logic [HALF_W-1:0]        half;
    logic [PART_W-1:0]        part;
    logic [ACC_W-1:0]         rnd;
    logic [WIDE_W-1:0]        r_clip;
    logic signed [WIDE_W-1:0] term;
    logic signed [WIDE_W-1:0] addend;

    assign x_off = (VAL_W+1)'(query_reg) - (VAL_W+1)'(x_origin_reg);

    always_comb
    begin
        op_neg = 1'b0;
        mag    = '0;
        mult   = inv_spacing_reg;
        addend = '0;
        case (cmd.op)
            OP_LOC_LO, OP_LOC_HI:
            begin
                mag = WIDE_W'(x_off[VAL_W-1:0]);
            end
            OP_V_LO, OP_V_HI, OP_V_ADD:
            begin
                op_neg = val_reg[WIDE_W-1];
                mag    = op_neg ? WIDE_W'(-val_reg) : WIDE_W'(val_reg);
                mult   = VAL_W'(p_reg);
                case (cmd.idx)
                    CNT_W'(0): addend = cc_reg;
                    CNT_W'(1): addend = s_reg[0];
                    default:   addend = WIDE_W'(w_reg[WIN_BACK]);
                endcase
            end
            OP_H_LO, OP_H_HI, OP_H_ADD:
            begin
                op_neg = h_reg[WIDE_W-1];
                mag    = op_neg ? WIDE_W'(-h_reg) : WIDE_W'(h_reg);
                // last step scales the per-cell slope to d/dx
                mult   = (cmd.idx == HORNER_LAST) ? inv_spacing_reg : VAL_W'(p_reg);
                case (cmd.idx)
                    CNT_W'(0): addend = cc_reg <<< 1;
                    CNT_W'(1): addend = s_reg[0];
                    default:   addend = '0;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign is_lo  = (cmd.op == OP_LOC_LO) || (cmd.op == OP_V_LO) || (cmd.op == OP_H_LO);
    assign half   = is_lo ? mag[HALF_W-1:0] : mag[WIDE_W-1:HALF_W];
    assign part   = PART_W'(half) * PART_W'(mult);
    assign rnd    = (acc_reg + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign r_clip = (rnd > ACC_W'(MUL_CAP)) ? MUL_CAP : rnd[WIDE_W-1:0];
    assign term   = op_neg ? -$signed(r_clip) : $signed(r_clip);

    // ------------------------------------------------------------------
    // cell lookup
    logic [ACC_W-1:0] k_val;
    logic [ACC_W-1:0] last_cell;

    assign k_val     = acc_reg >> (2 * FRAC_BITS);
    assign last_cell = ACC_W'(n_pts) - ACC_W'(1);

    // ------------------------------------------------------------------
    // node slopes; lane 0 is the left node of the cell, lane 1 the right
    logic [NW-1:0]            node [2];
    logic signed [VAL_W:0]    fwd [2];
    logic signed [VAL_W:0]    bwd [2];
    logic signed [VAL_W:0]    cen [2];
    logic [VAL_W:0]           cen_mag [2];
    logic [VAL_W:0]           half_q [2];
    logic signed [XW-1:0]     inner [2];
    logic [XW-1:0]            inner_mag [2];
    logic [DIV_W-1:0]         numer [2];
    slope_kind_t              kind [2];
    logic signed [WIDE_W-1:0] s_imm [2];
    logic [DIV_W-1:0]         quot [2];
    logic signed [WIDE_W-1:0] s_fin [2];

    always_comb
    begin
        for (int o = 0; o < 2; o++)
        begin
            node[o]    = NW'(cell_reg) + NW'(o);
            fwd[o]     = (VAL_W+1)'(w_reg[3+o]) - (VAL_W+1)'(w_reg[2+o]);
            bwd[o]     = (VAL_W+1)'(w_reg[2+o]) - (VAL_W+1)'(w_reg[1+o]);
            cen[o]     = (VAL_W+1)'(w_reg[3+o]) - (VAL_W+1)'(w_reg[1+o]);
            cen_mag[o] = cen[o][VAL_W] ? (VAL_W+1)'(-cen[o]) : (VAL_W+1)'(cen[o]);
            half_q[o]  = (cen_mag[o] + (VAL_W+1)'(1)) >> 1;
            inner[o]   = XW'(w_reg[o]) - XW'(w_reg[4+o]) + (XW'(cen[o]) <<< 3);
            inner_mag[o] = inner[o][XW-1] ? XW'(-inner[o]) : XW'(inner[o]);
            // round(m / 12) = floor(floor((m + 6) / 4) / 3)
            numer[o]   = DIV_W'((inner_mag[o] + XW'(6)) >> 2);

            if (node[o] == '0)
            begin
                kind[o] = SK_FWD;
            end
            else if (node[o] == NW'(1))
            begin
                kind[o] = SK_HALF;
            end
            else if (node[o] == n_pts - NW'(2))
            begin
                kind[o] = SK_HALF;
            end
            else if (node[o] == n_pts - NW'(1))
            begin
                kind[o] = SK_BWD;
            end
            else
            begin
                kind[o] = SK_INNER;
            end

            case (kind[o])
                SK_FWD:  s_imm[o] = WIDE_W'(fwd[o]);
                SK_BWD:  s_imm[o] = WIDE_W'(bwd[o]);
                SK_HALF: s_imm[o] = cen[o][VAL_W] ? -$signed(WIDE_W'(half_q[o]))
                                                  : $signed(WIDE_W'(half_q[o]));
                default: s_imm[o] = '0;
            endcase

            if (kind_reg[o] == SK_INNER)
            begin
                s_fin[o] = sneg_reg[o] ? -$signed(WIDE_W'(quot[o]))
                                       : $signed(WIDE_W'(quot[o]));
            end
            else
            begin
                s_fin[o] = s_reg[o];
            end
        end
    end

    for (genvar g = 0; g < 2; g++)
    begin : g_div
        tcse_div3 u_div (
            .clk   (clk),
            .load  (cmd.op == OP_PREP),
            .step  (cmd.op == OP_DIV),
            .numer (numer[g]),
            .quot  (quot[g])
        );
    end

    // cubic coefficients
    logic signed [WIDE_W-1:0] dy;
    logic signed [WIDE_W-1:0] cc;
    logic signed [WIDE_W-1:0] dd;

    assign dy = WIDE_W'(w_reg[WIN_BACK+1]) - WIDE_W'(w_reg[WIN_BACK]);
    assign cc = (dy <<< 1) + dy - (s_fin[0] <<< 1) - s_fin[1];
    assign dd = s_fin[0] + s_fin[1] - (dy <<< 1);

    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                query_reg <= query_x;
            end
            OP_LOC_LO, OP_V_LO, OP_H_LO:
            begin
                acc_reg <= ACC_W'(part);
            end
            OP_LOC_HI, OP_V_HI, OP_H_HI:
            begin
                acc_reg <= acc_reg + (ACC_W'(part) << HALF_W);
            end
            OP_CELL:
            begin
                if (x_off[VAL_W])
                begin
                    cell_reg <= '0;
                    p_reg    <= '0;
                end
                else if (k_val >= last_cell)
                begin
                    cell_reg <= AW'(n_pts - NW'(2));
                    p_reg    <= PW'(1) << FRAC_BITS;
                end
                else
                begin
                    cell_reg <= AW'(k_val);
                    p_reg    <= PW'(acc_reg[2*FRAC_BITS-1:FRAC_BITS]);
                end
            end
            OP_READ:
            begin
                if (cmd.idx != '0)
                begin
                    w_reg[WIN_IDX_W'(cmd.idx - CNT_W'(1))] <= ram_rdata;
                end
            end
            OP_PREP:
            begin
                for (int o = 0; o < 2; o++)
                begin
                    s_reg[o]    <= s_imm[o];
                    kind_reg[o] <= kind[o];
                    sneg_reg[o] <= inner[o][XW-1];
                end
            end
            OP_FIN:
            begin
                s_reg[0] <= s_fin[0];
                s_reg[1] <= s_fin[1];
                cc_reg   <= cc;
                val_reg  <= dd;
                h_reg    <= (dd <<< 1) + dd;
            end
            OP_V_ADD:
            begin
                val_reg <= term + addend;
            end
            OP_H_ADD:
            begin
                h_reg <= term + addend;
            end
            OP_OUT:
            begin
                fv_reg <= sat_val(val_reg);
                fs_reg <= sat_val(h_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign func_value = fv_reg;
    assign func_slope = fs_reg;

endmodule

FILE: src/tabulated_cubic_spline_eval.sv
// Cubic Hermite interpolation over a uniformly gridded table of signed Q16.16 samples.
// An input transaction with action 0 writes one sample and yields no result; action 1
// evaluates at query_x and yields one result transaction carrying the saturated value and
// derivative. A query occupies the block from accept to the next accept: cell lookup on
// the shared 20x32 multiplier, six window reads from the sample memory's read port, slope
// setup and two radix-16 divide-by-3 lanes for the interior slopes, then two three-step
// Horner chains on the same multiplier, and the result register write, which waits out
// a stalled previous result. Samples up to num_points must be loaded before querying;
// configuration is to be written while idle, which the block itself does not enforce.
module tabulated_cubic_spline_eval import tcse_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    action,
    input  logic [IDX_W-1:0]        sample_index,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic signed [VAL_W-1:0] query_x,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [VAL_W-1:0] func_value,
    output logic signed [VAL_W-1:0] func_slope,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [VAL_W-1:0]        cfg_data
);

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    tcse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tcse_datapath #(
        .DEPTH     (TABLE_DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .query_x      (query_x),
        .func_value   (func_value),
        .func_slope   (func_slope)
    );

endmodule

FILE: test/tb_tabulated_cubic_spline_eval.sv
`timescale 1ns / 1ps

module tb_tabulated_cubic_spline_eval;
    import tcse_pkg::*;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] slope;
    } spline_res_t;

    localparam int DEPTH = 1024;
    localparam longint unsigned PROD_CAP = 64'd1 << 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic [IDX_W-1:0] sample_index = '0;
    logic signed [VAL_W-1:0] sample_value = '0;
    logic signed [VAL_W-1:0] query_x = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [VAL_W-1:0] func_value;
    logic signed [VAL_W-1:0] func_slope;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAL_W-1:0] cfg_data = '0;

    // predictor copy of the table and registers
    logic [VAL_W-1:0] grid_samples [DEPTH];
    logic [NUM_W-1:0] cur_num_points = NUM_POINTS_RST;
    logic signed [VAL_W-1:0] cur_origin = '0;
    logic [VAL_W-1:0] cur_inv_spacing = INV_SPACING_RST;

    spline_res_t pending_evals [$];
    int mismatch_count = 0;
    int hold_cycles = 0;
    bit quiet = 1'b0;

    tabulated_cubic_spline_eval i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .sample_index(sample_index),
        .sample_value(sample_value), .query_x(query_x),
        .out_valid(out_valid), .out_stall(out_stall),
        .func_value(func_value), .func_slope(func_slope),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(15, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic longint sample_at(int i);
        return longint'($signed(grid_samples[i]));
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint mul_fix(longint v, longint unsigned m);
        longint unsigned mag;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned r;
        m = m & 64'hFFFF_FFFF;
        mag = (v < 0) ? longint'(-v) : v;
        hi = mag >> 16;
        lo = mag & 64'hFFFF;
        if (hi != 0 && m > PROD_CAP / hi)
        begin
            r = PROD_CAP;
        end
        else
        begin
            r = hi * m + ((lo * m + 64'd32768) >> 16);
            if (r > PROD_CAP)
            begin
                r = PROD_CAP;
            end
        end
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint node_deriv(int i, int n);
        if (i == 0)
        begin
            return sample_at(1) - sample_at(0);
        end
        if (i == 1)
        begin
            return round_div(sample_at(2) - sample_at(0), 2);
        end
        if (i == n - 2)
        begin
            return round_div(sample_at(n - 1) - sample_at(n - 3), 2);
        end
        if (i == n - 1)
        begin
            return sample_at(n - 1) - sample_at(n - 2);
        end
        return round_div((sample_at(i - 2) - sample_at(i + 2))
                         + 8 * (sample_at(i + 1) - sample_at(i - 1)), 12);
    endfunction

    function automatic logic [VAL_W-1:0] clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[VAL_W-1:0];
    endfunction

    function automatic int points_used();
        int n;
        n = cur_num_points;
        if (n < MIN_POINTS)
        begin
            n = MIN_POINTS;
        end
        if (n > DEPTH)
        begin
            n = DEPTH;
        end
        return n;
    endfunction

    function automatic spline_res_t hermite_eval(logic signed [VAL_W-1:0] qx);
        spline_res_t res;
        int n;
        int cell_idx;
        longint x_off;
        longint unsigned p;
        longint unsigned q;
        longint unsigned k;
        longint y0, y1, s0, s1, dy, cc, dd, val, h;
        n = points_used();
        x_off = longint'(qx) - longint'(cur_origin);
        if (x_off < 0)
        begin
            cell_idx = 0;
            p = 0;
        end
        else
        begin
            q = ((x_off & 64'hFFFF_FFFF) * longint'(cur_inv_spacing)) >> 16;
            if ((x_off >> 32) != 0)
            begin
                q += longint'(cur_inv_spacing) << 16;
            end
            k = q >> 16;
            if (k >= n - 1)
            begin
                cell_idx = n - 2;
                p = 64'd65536;
            end
            else
            begin
                cell_idx = int'(k);
                p = q & 64'hFFFF;
            end
        end
        y0 = sample_at(cell_idx);
        y1 = sample_at(cell_idx + 1);
        s0 = node_deriv(cell_idx, n);
        s1 = node_deriv(cell_idx + 1, n);
        dy = y1 - y0;
        cc = 3 * dy - 2 * s0 - s1;
        dd = s0 + s1 - 2 * dy;
        val = mul_fix(mul_fix(mul_fix(dd, p) + cc, p) + s0, p) + y0;
        h = mul_fix(mul_fix(3 * dd, p) + 2 * cc, p) + s0;
        h = mul_fix(h, cur_inv_spacing);
        res.value = clip32(val);
        res.slope = clip32(h);
        return res;
    endfunction

    // called at a clock edge, returns at the edge where the transaction is taken
    task automatic send_item(logic act, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                             logic [VAL_W-1:0] qx);
        int gap;
        gap = quiet ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        sample_index <= idx;
        sample_value <= val;
        query_x <= qx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (act)
        begin
            pending_evals.push_back(hermite_eval(qx));
        end
        else
        begin
            grid_samples[idx] = val;
        end
    endtask

    task automatic load_sample(int idx, logic [VAL_W-1:0] val);
        send_item(1'b0, idx[IDX_W-1:0], val, $urandom);
    endtask

    task automatic eval_at(logic [VAL_W-1:0] qx);
        send_item(1'b1, IDX_W'($urandom_range(0, DEPTH - 1)), $urandom, qx);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending_evals.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [VAL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_NUM_POINTS:  cur_num_points = data[NUM_W-1:0];
            CFG_X_ORIGIN:    cur_origin = data;
            CFG_INV_SPACING: cur_inv_spacing = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(logic [VAL_W-1:0] npts, logic [VAL_W-1:0] org,
                            logic [VAL_W-1:0] inv);
        drain();
        write_reg(CFG_NUM_POINTS, npts);
        write_reg(CFG_X_ORIGIN, org);
        write_reg(CFG_INV_SPACING, inv);
    endtask

    // query point mostly spread over the grid and two cells on either side, else random
    function automatic logic [VAL_W-1:0] grid_point();
        longint spacing;
        longint span;
        longint x;
        if ($urandom_range(0, 4) == 0)
        begin
            return $urandom;
        end
        spacing = (cur_inv_spacing == 0) ? 65536 : ((64'd1 << 32) / cur_inv_spacing);
        if (spacing == 0)
        begin
            spacing = 1;
        end
        span = (points_used() + 3) * spacing;
        x = longint'(cur_origin) - 2 * spacing
            + longint'({$urandom, $urandom} % longint'(span));
        if (x > 64'sd2147483647)
        begin
            x = 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            x = -64'sd2147483648;
        end
        return x[VAL_W-1:0];
    endfunction

    task automatic fill_table(bit full_range);
        int n;
        logic [VAL_W-1:0] v;
        n = points_used();
        for (int i = 0; i < n; i++)
        begin
            v = full_range ? $urandom : VAL_W'($signed($urandom_range(0, 32'h1F_FFFF))
                                              - 32'sh10_0000);
            load_sample(i, v);
        end
    endtask

    task automatic test_directed();
        load_sample(0, 32'h0000_0000);
        load_sample(1, 32'h0001_0000);
        load_sample(2, 32'h0004_0000);
        load_sample(3, 32'h0009_0000);
        load_sample(4, 32'h0010_0000);
        eval_at(32'hFFFF_0000);      // left of origin
        eval_at(32'h0000_0000);
        eval_at(32'h0002_8000);
        eval_at(32'h0001_4000);
        eval_at(32'h0004_0000);      // on the last node
        eval_at(32'h0064_0000);      // far past the end
        eval_at(32'h7FFF_FFFF);
        eval_at(32'h8000_0000);
        load_sample(0, 32'h7FFF_FFFF);
        load_sample(1, 32'h8000_0000);
        load_sample(2, 32'h7FFF_FFFF);
        load_sample(3, 32'h8000_0000);
        load_sample(4, 32'h7FFF_FFFF);
        eval_at(32'h0000_8000);
        eval_at(32'h0002_C000);
        eval_at(32'h0003_FFFF);
        // zero spacing reciprocal pins every query to the first node
        set_grid(0, 32'h0000_0000, 32'h0000_0000);
        eval_at(32'h0002_8000);
        eval_at(32'hFFFF_0000);
    endtask

    task automatic test_random();
        logic [VAL_W-1:0] npts [8];
        logic [VAL_W-1:0] orgs [8];
        logic [VAL_W-1:0] invs [8];
        int evals;
        npts = '{12, 0, 20, 33, 7, 300, 40, 9};
        orgs = '{$urandom, 32'h8000_0000, 32'h7FFF_FFFF, $urandom,
                 $urandom, 0, $urandom, $urandom};
        invs = '{32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0002_0000,
                 32'h0000_8000, 32'h0001_0000, $urandom, 32'h0000_0000};
        for (int ph = 0; ph < 8; ph++)
        begin
            set_grid(npts[ph], orgs[ph], invs[ph]);
            quiet = (ph % 3 == 2);
            fill_table(ph % 2);
            evals = 45;
            for (int i = 0; i < evals; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    load_sample($urandom_range(0, points_used() - 1),
                                (ph % 2) ? $urandom : $urandom_range(0, 32'h3F_FFFF));
                end
                eval_at(grid_point());
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        drain();
        hold_cycles = 500;
        for (int i = 0; i < 12; i++)
        begin
            eval_at(grid_point());
        end
    endtask

    // result sink stalls
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        spline_res_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_evals.size() == 0)
            begin
                $error("unexpected result transaction value=%h slope=%h",
                       func_value, func_slope);
                mismatch_count++;
            end
            else
            begin
                exp_res = pending_evals.pop_front();
                if (func_value !== exp_res.value)
                begin
                    $error("func_value expected %h actual %h", exp_res.value, func_value);
                    mismatch_count++;
                end
                if (func_slope !== exp_res.slope)
                begin
                    $error("func_slope expected %h actual %h", exp_res.slope, func_slope);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #25ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        drain();
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/tcse_pkg.sv
src/tcse_ram.sv
src/tcse_div3.sv
src/tcse_ctrl.sv
src/tcse_datapath.sv
src/tabulated_cubic_spline_eval.sv
test/tb_tabulated_cubic_spline_eval.sv
